@@ rtl/core/msx_pkg.sv @@
package msx_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_GT    = 8'h3E;

   // index 0 is the first marker byte
   localparam logic [3:0][7:0] MARKER_AT    = {8'h29, 8'h23, 8'h28, 8'h40};
   localparam logic [3:0][7:0] MARKER_TILDE = {8'h60, 8'h5E, 8'h7C, 8'h7E};

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_file;
      logic       is_term;
      logic [3:0] hit_at;
      logic [3:0] hit_tilde;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   function automatic logic is_terminator(input logic [7:0] b);
      return (b == CH_NUL) || (b == CH_QUOTE) || (b == CH_BSL) ||
             (b == CH_GT) || (b == CH_NL);
   endfunction

endpackage

@@ rtl/core/msx_front.sv @@
module msx_front
   import msx_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_byte_value,
   input  logic          req_end_of_file,
   output queue_out_type q_out,
   input  logic          q_pop
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

   item_type            mem [QueueDepth];
   item_type            item_in;
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push;
   logic                pop;

   always_comb begin
      item_in.byte_value  = req_byte_value;
      item_in.end_of_file = req_end_of_file;
      item_in.is_term     = is_terminator(req_byte_value);
      for (int i = 0; i < 4; i++) begin
         item_in.hit_at[2'(i)]    = (req_byte_value == MARKER_AT[2'(i)]);
         item_in.hit_tilde[2'(i)] = (req_byte_value == MARKER_TILDE[2'(i)]);
      end
   end

   assign req_stall = (count_ff == FullCnt);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (count_ff != '0);

   assign wr_ptr_in = push ? ((wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? ((rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= item_in;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.item  = mem[rd_ptr_ff];

endmodule

@@ rtl/core/msx_back.sv @@
module msx_back
   import msx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  queue_out_type q_out,
   output logic          q_pop,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic          csr_silent_mode,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_closes_entry,
   output logic          rsp_found_any
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_AT,
      PH_TILDE,
      PH_COPY,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  pos_ff, pos_in;
   logic        found_ff, found_in;
   logic        silent_ff, silent_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        closes_ff, closes_in;
   logic        found_out_ff, found_out_in;
   logic        out_free;
   logic        emit;
   logic        hit;
   item_type    it;

   assign it       = q_out.item;
   assign out_free = !valid_ff || !rsp_stall;
   assign q_pop    = q_out.valid && out_free;
   assign hit      = (phase_ff == PH_AT) ? it.hit_at[pos_ff] : it.hit_tilde[pos_ff];

   assign silent_in = (csr_valid && csr_ready) ? csr_silent_mode : silent_ff;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      found_in  = found_ff;
      emit      = 1'b0;
      byte_in   = byte_ff;
      closes_in = closes_ff;
      if (q_pop) begin
         if (it.end_of_file) begin
            phase_in = PH_IDLE;
            pos_in   = '0;
            if (phase_ff == PH_COPY) begin
               emit      = 1'b1;
               byte_in   = CH_NL;
               closes_in = 1'b1;
            end
         end else begin
            case (phase_ff)
               PH_AT, PH_TILDE: begin
                  if (pos_ff != 2'd0 && hit) begin
                     if (pos_ff == 2'd3) begin
                        found_in  = 1'b1;
                        phase_in  = PH_COPY;
                        pos_in    = '0;
                        emit      = 1'b1;
                        byte_in   = CH_TAB;
                        closes_in = 1'b0;
                     end else begin
                        pos_in = pos_ff + 2'd1;
                     end
                  end else if (it.hit_at[0]) begin
                     phase_in = PH_AT;
                     pos_in   = 2'd1;
                  end else if (it.hit_tilde[0]) begin
                     phase_in = PH_TILDE;
                     pos_in   = 2'd1;
                  end else begin
                     phase_in = PH_IDLE;
                     pos_in   = '0;
                  end
               end
               PH_COPY: begin
                  emit = 1'b1;
                  if (it.is_term) begin
                     phase_in  = silent_ff ? PH_DONE : PH_IDLE;
                     pos_in    = '0;
                     byte_in   = CH_NL;
                     closes_in = 1'b1;
                  end else begin
                     byte_in   = it.byte_value;
                     closes_in = 1'b0;
                  end
               end
               PH_DONE: begin
               end
               default: begin
                  if (it.hit_at[0]) begin
                     phase_in = PH_AT;
                     pos_in   = 2'd1;
                  end else if (it.hit_tilde[0]) begin
                     phase_in = PH_TILDE;
                     pos_in   = 2'd1;
                  end else begin
                     phase_in = PH_IDLE;
                     pos_in   = '0;
                  end
               end
            endcase
         end
      end
      found_out_in = emit ? found_in : found_out_ff;
      if (out_free) begin
         valid_in = emit;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         found_ff  <= 1'b0;
         silent_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         found_ff  <= found_in;
         silent_ff <= silent_in;
         valid_ff  <= valid_in;
      end
      if (emit) begin
         byte_ff      <= byte_in;
         closes_ff    <= closes_in;
         found_out_ff <= found_out_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_closes_entry = closes_ff;
   assign rsp_found_any    = found_out_ff;

endmodule

@@ rtl/core/marker_string_extractor.sv @@
// Marker string extractor: scans a byte stream for "@(#)" or "~|^`" and
// emits each identification entry as a tab, the copied bytes, and a
// closing newline.
// Input channel (req_): one beat per byte, or one beat with end_of_file
// set to close the current file. req_stall rises when the input queue is
// full.
// Result channel (rsp_): zero or one beat per input beat, in input order,
// held stable while rsp_stall is high.
// Config channel (csr_): silent_mode, always ready; write it only while
// the block is idle.
// Throughput is one byte per cycle while the receiver does not stall the
// result register, set by the scan state machine in the back end. The
// result beat of an accepted byte passes through the input queue and then
// into the result register.
// Reset clears the queue, the scan state, the found flag and silent_mode.
// When the receiver stalls, the result register holds, the queue fills
// within QueueDepth beats and req_stall is raised.
module marker_string_extractor
   import msx_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   input  logic       req_end_of_file,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_closes_entry,
   output logic       rsp_found_any,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_silent_mode
);

   queue_out_type q_out;
   logic          q_pop;

   assign csr_ready = 1'b1;

   msx_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_value  (req_byte_value),
      .req_end_of_file (req_end_of_file),
      .q_out           (q_out),
      .q_pop           (q_pop)
   );

   msx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_out            (q_out),
      .q_pop            (q_pop),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_silent_mode  (csr_silent_mode),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_closes_entry (rsp_closes_entry),
      .rsp_found_any    (rsp_found_any)
   );

endmodule
